[design/specular_cube_map_texel_core_defines.svh]
// assertion macros shared by the specular cube map texel core
// no dependencies; included by the files that carry assertions
`ifndef SPECULAR_CUBE_MAP_TEXEL_CORE_DEFINES_SVH
`define SPECULAR_CUBE_MAP_TEXEL_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SCM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define SCM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/scm_pkg.sv]
// shared types and constants of the specular cube map texel core
// no dependencies; imported by every module of the core
package scm_pkg;

  // texel coordinate width; face size is 2**COORD_W texels
  localparam int COORD_W    = 7;
  localparam int SHININESS  = 20;
  localparam int POW_STAGES = SHININESS - 1;

  // reciprocal square root: r*r*m <= 2**RSQ_LIM_LOG, one result bit per stage
  localparam int RSQ_BITS    = 16;
  localparam int RSQ_LIM_LOG = 44;
  localparam int RSQ_ACC_W   = 49;
  localparam int RSQ_Q_W     = 32;
  localparam int M_W         = 16;
  localparam logic [M_W-1:0] M_BIAS = 16'h4000;

  localparam logic [24:0] P_CAP = 25'h100_0000;

  // cube faces
  localparam logic [2:0] FACE_NEG_X = 3'd0;
  localparam logic [2:0] FACE_NEG_Y = 3'd1;
  localparam logic [2:0] FACE_NEG_Z = 3'd2;
  localparam logic [2:0] FACE_POS_X = 3'd3;
  localparam logic [2:0] FACE_POS_Y = 3'd4;
  localparam logic [2:0] FACE_POS_Z = 3'd5;

  // register indexes
  localparam logic [2:0] REG_LIGHT_X    = 3'd0;
  localparam logic [2:0] REG_LIGHT_Y    = 3'd1;
  localparam logic [2:0] REG_LIGHT_Z    = 3'd2;
  localparam logic [2:0] REG_GAIN_RED   = 3'd3;
  localparam logic [2:0] REG_GAIN_GREEN = 3'd4;
  localparam logic [2:0] REG_GAIN_BLUE  = 3'd5;

  typedef struct packed {
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
    logic [8:0]         gain_red;
    logic [8:0]         gain_green;
    logic [8:0]         gain_blue;
  } scm_cfg_t;

  typedef struct packed {
    logic signed [7:0] a;
    logic signed [7:0] b;
    logic [2:0]        face;
  } scm_coord_t;

  typedef struct packed {
    logic                 vld;
    logic [RSQ_ACC_W-1:0] p;
    logic [RSQ_Q_W-1:0]   q;
    logic [RSQ_BITS-1:0]  r;
    logic [M_W-1:0]       m;
    scm_coord_t           crd;
  } scm_rsq_t;

  typedef struct packed {
    logic                vld;
    logic [RSQ_BITS-1:0] r;
    scm_coord_t          crd;
  } scm_norm_t;

  typedef struct packed {
    logic        vld;
    logic        black;
    logic [16:0] d;
  } scm_dot_t;

  typedef struct packed {
    logic        vld;
    logic        black;
    logic [24:0] p;
    logic [16:0] d;
  } scm_pow_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } scm_rgb_t;

endpackage

[design/scm_norm.sv]
// coordinate mapping and pipelined reciprocal square root of (x, y, 1)
// depends on scm_pkg
module scm_norm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [scm_pkg::COORD_W-1:0]   column,
  input  logic [scm_pkg::COORD_W-1:0]   row,
  input  logic [2:0]                    face,
  output scm_pkg::scm_norm_t            out
);
  import scm_pkg::*;

  localparam logic [RSQ_ACC_W-1:0] RSQ_LIM = RSQ_ACC_W'(1) << RSQ_LIM_LOG;

  scm_rsq_t          st [0:RSQ_BITS];
  logic signed [7:0] a;
  logic signed [7:0] b;
  logic signed [15:0] aa;
  logic signed [15:0] bb;

  // 2c - size flips the top bit when size is a power of two; x = a / 128
  assign a  = {~column[COORD_W-1], column[COORD_W-2:0], 1'b0};
  assign b  = {~row[COORD_W-1], row[COORD_W-2:0], 1'b0};
  assign aa = 16'(a) * 16'(a);
  assign bb = 16'(b) * 16'(b);

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].vld <= 1'b0;
    end else if (en) begin
      st[0].vld      <= in_vld;
      st[0].p        <= '0;
      st[0].q        <= '0;
      st[0].r        <= '0;
      st[0].m        <= $unsigned(aa) + $unsigned(bb) + M_BIAS;
      st[0].crd.a    <= a;
      st[0].crd.b    <= b;
      st[0].crd.face <= face;
    end
  end

  // p tracks r*r*m and q tracks r*m, so each trial bit is adds and shifts only
  for (genvar k = 0; k < RSQ_BITS; k++) begin : g_bit
    localparam int B = RSQ_BITS - 1 - k;
    scm_rsq_t             nxt;
    logic [RSQ_ACC_W-1:0] trial;

    always_comb begin
      trial = st[k].p + (RSQ_ACC_W'(st[k].q) << (B + 1))
            + (RSQ_ACC_W'(st[k].m) << (2 * B));
      nxt = st[k];
      if (trial <= RSQ_LIM) begin
        nxt.p = trial;
        nxt.q = st[k].q + (RSQ_Q_W'(st[k].m) << B);
        nxt.r = st[k].r | (RSQ_BITS'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[k+1].vld <= 1'b0;
      end else if (en) begin
        st[k+1] <= nxt;
      end
    end
  end

  assign out.vld = st[RSQ_BITS].vld;
  assign out.r   = st[RSQ_BITS].r;
  assign out.crd = st[RSQ_BITS].crd;

endmodule

[design/scm_light.sv]
// scales the normalized texel vector, applies the face mapping and forms the
// dot product with the light direction; depends on scm_pkg
module scm_light (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  scm_pkg::scm_cfg_t  cfg,
  input  scm_pkg::scm_norm_t in,
  output scm_pkg::scm_dot_t  out
);
  import scm_pkg::*;

  logic signed [16:0] rr;
  logic signed [24:0] sr;
  logic signed [24:0] tr;
  logic signed [24:0] sr_adj;
  logic signed [24:0] tr_adj;
  logic signed [16:0] s;
  logic signed [16:0] t;
  logic signed [16:0] fx;
  logic signed [16:0] fy;
  logic signed [16:0] fz;
  logic               bad_face;

  logic               v1;
  logic               k1;
  logic signed [16:0] fx_q;
  logic signed [16:0] fy_q;
  logic signed [16:0] fz_q;

  logic               v2;
  logic               k2;
  logic signed [32:0] px;
  logic signed [32:0] py;
  logic signed [32:0] pz;
  logic signed [34:0] sum;

  assign rr = $signed({1'b0, in.r});
  assign sr = 25'(in.crd.a) * 25'(rr);
  assign tr = 25'(in.crd.b) * 25'(rr);
  // divide by 128 rounding toward zero
  assign sr_adj = sr + (sr[24] ? 25'sd127 : 25'sd0);
  assign tr_adj = tr + (tr[24] ? 25'sd127 : 25'sd0);
  assign s = sr_adj[23:7];
  assign t = tr_adj[23:7];

  always_comb begin
    bad_face = 1'b0;
    fx = '0;
    fy = '0;
    fz = '0;
    unique case (in.crd.face)
      FACE_NEG_X: begin
        fx = -rr; fy = t;   fz = s;
      end
      FACE_NEG_Y: begin
        fx = s;   fy = -rr; fz = t;
      end
      FACE_NEG_Z: begin
        fx = -s;  fy = t;   fz = -rr;
      end
      FACE_POS_X: begin
        fx = rr;  fy = t;   fz = -s;
      end
      FACE_POS_Y: begin
        fx = s;   fy = rr;  fz = -t;
      end
      FACE_POS_Z: begin
        fx = s;   fy = t;   fz = rr;
      end
      default: begin
        bad_face = 1'b1;
      end
    endcase
  end

  assign sum = 35'(px) + 35'(py) + 35'(pz);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out.vld <= 1'b0;
    end else if (en) begin
      v1 <= in.vld;
      v2 <= v1;
      out.vld <= v2;
    end
    if (en) begin
      k1   <= bad_face;
      fx_q <= fx;
      fy_q <= fy;
      fz_q <= fz;
      k2   <= k1;
      px   <= 33'(cfg.light_x) * 33'(fx_q);
      py   <= 33'(cfg.light_y) * 33'(fy_q);
      pz   <= 33'(cfg.light_z) * 33'(fz_q);
      // a positive sum stays below 2**32, so q.15 of it fits 17 bits
      out.black <= k2 | (sum <= 35'sd0);
      out.d     <= sum[31:15];
    end
  end

endmodule

[design/scm_pow.sv]
// shininess power: one truncating multiply by d per stage, capped
// depends on scm_pkg
module scm_pow (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  scm_pkg::scm_dot_t in,
  output scm_pkg::scm_pow_t out
);
  import scm_pkg::*;

  scm_pow_t pw [0:POW_STAGES];

  always_comb begin
    pw[0].vld   = in.vld;
    pw[0].black = in.black;
    pw[0].p     = 25'(in.d);
    pw[0].d     = in.d;
  end

  for (genvar k = 0; k < POW_STAGES; k++) begin : g_stage
    logic [41:0] prod;
    logic [26:0] sh;

    assign prod = 42'(pw[k].p) * 42'(pw[k].d);
    assign sh   = prod[41:15];

    always_ff @(posedge clk) begin
      if (rst) begin
        pw[k+1].vld <= 1'b0;
      end else if (en) begin
        pw[k+1].vld   <= pw[k].vld;
        pw[k+1].black <= pw[k].black;
        pw[k+1].d     <= pw[k].d;
        pw[k+1].p     <= (sh > 27'(P_CAP)) ? P_CAP : sh[24:0];
      end
    end
  end

  assign out = pw[POW_STAGES];

endmodule

[design/scm_shade.sv]
// channel scaling by 255 and gain with saturation, then the output register
// and skid stage; depends on scm_pkg and the core's assertion macros
`include "specular_cube_map_texel_core_defines.svh"

module scm_shade (
  input  logic              clk,
  input  logic              rst,
  input  scm_pkg::scm_cfg_t cfg,
  input  scm_pkg::scm_pow_t in,
  output logic              en,
  output logic              m_valid,
  input  logic              m_ready,
  output scm_pkg::scm_rgb_t m_data
);
  import scm_pkg::*;

  logic        c_vld;
  logic        c_black;
  logic [32:0] p255;
  logic [41:0] prod_r;
  logic [41:0] prod_g;
  logic [41:0] prod_b;
  scm_rgb_t    rgb;
  logic        skid_valid;
  scm_rgb_t    skid_data;
  logic        take;
  logic        out_free;

  function automatic logic [7:0] sat8(input logic [41:0] v);
    logic [18:0] x;
    x = v[41:23];
    return (x > 19'd255) ? 8'hff : x[7:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_black <= in.black;
      p255    <= {in.p, 8'b0} - {8'b0, in.p};
    end
  end

  assign prod_r = 42'(p255) * 42'(cfg.gain_red);
  assign prod_g = 42'(p255) * 42'(cfg.gain_green);
  assign prod_b = 42'(p255) * 42'(cfg.gain_blue);

  always_comb begin
    rgb.red   = c_black ? 8'd0 : sat8(prod_r);
    rgb.green = c_black ? 8'd0 : sat8(prod_g);
    rgb.blue  = c_black ? 8'd0 : sat8(prod_b);
  end

  // pipeline moves while the skid entry is free, so an arriving item always has a slot
  assign en       = ~skid_valid;
  assign take     = c_vld & en;
  assign out_free = ~m_valid | m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (out_free) begin
        m_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_free) begin
      m_valid    <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (out_free) begin
        m_data <= rgb;
      end else begin
        skid_data <= rgb;
      end
    end else if (out_free && skid_valid) begin
      m_data <= skid_data;
    end
  end

  `SCM_ASSERT_IMP(a_skid_behind_out, clk, rst, !m_valid, !skid_valid, "skid holds an item while output is empty")
  `SCM_ASSERT_NXT(a_stall_to_skid, clk, rst, take && !out_free, skid_valid, "item stalled at output was not parked")
  `SCM_ASSERT_NXT(a_skid_drains, clk, rst, skid_valid && m_ready, m_valid && !skid_valid, "skid item not moved to output")

endmodule

[design/specular_cube_map_texel_core.sv]
// throughput: one item per cycle while s_tready is high; 16 reciprocal square root
// stages, 3 dot product stages, 19 power stages and 2 shading stages, all moving together
// s_tready drops only while the skid entry behind the output register is full
// reset (synchronous, active high) clears all valid bits and loads the register defaults
// top level: apb register file and pipeline wiring; depends on scm_pkg and all scm_ modules
module specular_cube_map_texel_core (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [6:0] column, [13:7] row, [15:14] zero
  input  logic [2:0]  s_tuser,   // [2:0] face
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);
  import scm_pkg::*;

  scm_cfg_t   cfg;
  logic [2:0] reg_idx;
  logic       wr;
  logic       en;
  scm_norm_t  norm;
  scm_dot_t   dot;
  scm_pow_t   pw;
  scm_rgb_t   rgb;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr      = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_x    <= 16'sd0;
      cfg.light_y    <= 16'sd0;
      cfg.light_z    <= 16'sd32767;
      cfg.gain_red   <= 9'd154;
      cfg.gain_green <= 9'd154;
      cfg.gain_blue  <= 9'd154;
    end else if (wr) begin
      unique case (reg_idx)
        REG_LIGHT_X:    cfg.light_x    <= pwdata[15:0];
        REG_LIGHT_Y:    cfg.light_y    <= pwdata[15:0];
        REG_LIGHT_Z:    cfg.light_z    <= pwdata[15:0];
        REG_GAIN_RED:   cfg.gain_red   <= pwdata[8:0];
        REG_GAIN_GREEN: cfg.gain_green <= pwdata[8:0];
        REG_GAIN_BLUE:  cfg.gain_blue  <= pwdata[8:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LIGHT_X:    prdata = {16'b0, cfg.light_x};
      REG_LIGHT_Y:    prdata = {16'b0, cfg.light_y};
      REG_LIGHT_Z:    prdata = {16'b0, cfg.light_z};
      REG_GAIN_RED:   prdata = {23'b0, cfg.gain_red};
      REG_GAIN_GREEN: prdata = {23'b0, cfg.gain_green};
      REG_GAIN_BLUE:  prdata = {23'b0, cfg.gain_blue};
      default:        prdata = 32'b0;
    endcase
  end

  assign s_tready = en;

  scm_norm u_norm (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (s_tvalid & en),
    .column (s_tdata[COORD_W-1:0]),
    .row    (s_tdata[2*COORD_W-1:COORD_W]),
    .face   (s_tuser),
    .out    (norm)
  );

  scm_light u_light (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .cfg (cfg),
    .in  (norm),
    .out (dot)
  );

  scm_pow u_pow (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .in  (dot),
    .out (pw)
  );

  scm_shade u_shade (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in      (pw),
    .en      (en),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_data  (rgb)
  );

  assign m_tdata = {rgb.blue, rgb.green, rgb.red};

endmodule
